>>> hdl/dfd_pkg.sv
package dfd_pkg;

    localparam int MAX_DIGITS  = 37;
    localparam int DIGIT_W     = 4;
    localparam int HIGH_W      = 64;
    localparam int LOW_W       = 59;
    localparam int WEIGHT_W    = HIGH_W + LOW_W;
    localparam int FRAC_W      = HIGH_W;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HIGH_W-1:0] W_HIGH_INIT = 64'h1999_9999_9999_9999;
    localparam logic [LOW_W-1:0]  W_LOW_INIT  = 59'h4CC_CCCC_CCCC_CCCC;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef weight_t weight_table_t [MAX_DIGITS];

    typedef struct packed {
        weight_t prod;
        logic    last;
    } q_entry_t;

    function automatic weight_table_t build_weights();
        weight_table_t tbl;
        weight_t       w;
        w = {W_HIGH_INIT, W_LOW_INIT};
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            tbl[i] = w;
            w      = w / 10;
        end
        return tbl;
    endfunction

    localparam weight_table_t WEIGHTS = build_weights();

endpackage

>>> hdl/dfd_if.sv
interface dfd_in_if import dfd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               has_digit;
    logic               last;

    modport source (output valid, output digit, output has_digit, output last, input ready);
    modport sink   (input valid, input digit, input has_digit, input last, output ready);
endinterface

interface dfd_out_if import dfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FRAC_W-1:0] fraction;

    modport source (output valid, output fraction, input ready);
    modport sink   (input valid, input fraction, output ready);
endinterface

>>> hdl/decimal_fraction_decoder.sv
// Decimal fraction decoder: turns the digits after a decimal point into a
// rounded 64-bit binary fraction (value times 2^64).
// digits: one transaction per digit, most significant first. has_digit
//   marks a real digit; last closes the string. A lone transaction with
//   has_digit low and last high is an empty string and yields zero.
//   Only the first 37 digits of a string count; later ones are dropped.
// result: one transaction per string, carrying fraction.
// A result passes the queue, the staging register, then the output register.
// Throughput: one transaction per cycle while ready is high, set by the
//   123-bit accumulate in the back end; place weights come from a constant
//   table indexed by the digit count, so no divider sits in the loop.
// A two-entry queue parts the digit front end from the accumulator, and an
//   output register holds the result, so a stalled receiver first fills the
//   output and staging registers, then the queue, and only then drops ready.
// Reset clears the digit count, the accumulator and every valid flag; the
//   block is ready in the first cycle after reset is released.
module decimal_fraction_decoder import dfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dfd_in_if.sink     digits,
    dfd_out_if.source  result
);

    logic     q_full;
    logic     q_not_empty;
    logic     push;
    logic     pop;
    q_entry_t push_entry;
    q_entry_t head;

    dfd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .digits     (digits),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    dfd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    dfd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (q_not_empty),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

endmodule

>>> hdl/dfd_front.sv
module dfd_front import dfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dfd_in_if.sink     digits,
    input  logic       q_full,
    output logic       push,
    output q_entry_t   push_entry
);

    logic [CNT_W-1:0] taken_reg;
    logic [CNT_W-1:0] taken_next;
    logic             accept;
    logic             take;
    weight_t          weight;
    weight_t          prod;

    assign digits.ready = !q_full;
    assign accept       = digits.valid && !q_full;
    assign take         = digits.has_digit && (taken_reg < CNT_W'(MAX_DIGITS));

    always_comb
    begin
        weight = '0;
        if (take)
        begin
            weight = WEIGHTS[taken_reg[IDX_W-1:0]];
        end
        prod = '0;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            if (digits.digit[i])
            begin
                prod = prod + (weight << i);
            end
        end
    end

    assign push            = accept && (take || digits.last);
    assign push_entry.prod = prod;
    assign push_entry.last = digits.last;

    always_comb
    begin
        taken_next = taken_reg;
        if (accept)
        begin
            if (digits.last)
            begin
                taken_next = '0;
            end
            else if (take)
            begin
                taken_next = taken_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else
        begin
            taken_reg <= taken_next;
        end
    end

endmodule

>>> hdl/dfd_queue.sv
module dfd_queue import dfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output q_entry_t head
);

    q_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/dfd_back.sv
module dfd_back import dfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     not_empty,
    input  q_entry_t head,
    output logic     pop,
    dfd_out_if.source result
);

    weight_t           sum_reg;
    weight_t           sum_next;
    weight_t           total;
    weight_t           tot_reg;
    logic              tot_valid_reg;
    logic              tot_valid_next;
    logic [FRAC_W-1:0] frac_reg;
    logic [FRAC_W-1:0] frac_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              tot_move;
    logic              tot_free;

    assign out_free = !out_valid_reg || result.ready;
    assign tot_move = tot_valid_reg && out_free;
    assign tot_free = !tot_valid_reg || out_free;
    assign pop      = not_empty && (!head.last || tot_free);
    assign total    = sum_reg + head.prod;

    always_comb
    begin
        sum_next       = sum_reg;
        tot_valid_next = tot_valid_reg && !tot_move;
        if (pop)
        begin
            if (head.last)
            begin
                sum_next       = '0;
                tot_valid_next = 1'b1;
            end
            else
            begin
                sum_next = total;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        frac_next      = frac_reg;
        if (tot_move)
        begin
            out_valid_next = 1'b1;
            frac_next      = tot_reg[WEIGHT_W-1:LOW_W] + FRAC_W'(tot_reg[LOW_W-1]);
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.fraction = frac_reg;

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            tot_reg <= total;
        end
        frac_reg <= frac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            tot_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            tot_valid_reg <= tot_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/dfd_checker.sv
module dfd_checker import dfd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_last,
    input logic              out_valid,
    input logic              out_ready,
    input logic [FRAC_W-1:0] fraction
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       last_in;
    logic       res_out;

    assign last_in = in_valid && in_ready && in_last;
    assign res_out = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (last_in && !res_out)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (res_out && !last_in)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_quiet_in_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fraction))
        else $error("stalled result changed");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without a closing transaction");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more strings in flight than buffering allows");

endmodule

bind decimal_fraction_decoder dfd_checker u_dfd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (digits.valid),
    .in_ready  (digits.ready),
    .in_last   (digits.last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .fraction  (result.fraction)
);

>>> tb/sv/tb_decimal_fraction_decoder.sv
`timescale 1ns / 1ps

module tb_decimal_fraction_decoder;
    import dfd_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PCT = 36;

    class fraction_scoreboard;
        weight_t           place;
        weight_t           total;
        int unsigned       taken;
        logic [FRAC_W-1:0] fraction_q[$];
        int                errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            place = {W_HIGH_INIT, W_LOW_INIT};
            total = '0;
            taken = 0;
        endfunction

        function int pending();
            return fraction_q.size();
        endfunction

        function void note_digit(logic [DIGIT_W-1:0] d, logic h, logic l);
            logic [FRAC_W-1:0] rounded;
            if (h && taken < MAX_DIGITS)
            begin
                total = total + place * weight_t'(d);
                place = place / 10;
                taken++;
            end
            if (l)
            begin
                rounded = total[WEIGHT_W-1:LOW_W] + FRAC_W'(total[LOW_W-1]);
                fraction_q.push_back(rounded);
                restart();
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [FRAC_W-1:0] got);
            logic [FRAC_W-1:0] want;
            if (fraction_q.size() == 0)
                report($sformatf("unexpected fraction %h", got));
            else
            begin
                want = fraction_q.pop_front();
                if (got !== want)
                    report($sformatf("fraction %h, predicted %h", got, want));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   sent;
    int   stall_cycles;

    fraction_scoreboard sb;

    dfd_in_if  digit_ch ();
    dfd_out_if frac_ch ();

    decimal_fraction_decoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .digits (digit_ch),
        .result (frac_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit quiet();
        return sent >= 700 && sent < 1000;
    endfunction

    always @(posedge clk)
        frac_ch.ready <= quiet() ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (digit_ch.valid && digit_ch.ready)
                sb.note_digit(digit_ch.digit, digit_ch.has_digit, digit_ch.last);
            if (frac_ch.valid && frac_ch.ready)
                sb.check_result(frac_ch.fraction);
            if ((digit_ch.valid && digit_ch.ready) || (frac_ch.valid && frac_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [DIGIT_W-1:0] d, input logic h, input logic l);
        while (!quiet() && $urandom_range(99) < IDLE_PCT)
        begin
            digit_ch.valid <= 1'b0;
            @(posedge clk);
        end
        digit_ch.valid     <= 1'b1;
        digit_ch.digit     <= d;
        digit_ch.has_digit <= h;
        digit_ch.last      <= l;
        @(posedge clk);
        while (!digit_ch.ready)
            @(posedge clk);
        if (h || l)
            sent++;
    endtask

    task automatic pick_digit(input int mode, output logic [DIGIT_W-1:0] d);
        if (mode == 0)
            d = 4'd9;
        else if (mode == 1)
            d = 4'd15;
        else if ($urandom_range(99) < 8)
            d = DIGIT_W'($urandom_range(15, 10));
        else
            d = DIGIT_W'($urandom_range(9));
    endtask

    task automatic send_random_string();
        int                 len;
        int                 mode;
        int                 sel;
        bit                 split_last;
        logic [DIGIT_W-1:0] d;
        sel = $urandom_range(99);
        if (sel < 4)
            len = 0;
        else if (sel < 70)
            len = $urandom_range(8, 1);
        else if (sel < 85)
            len = $urandom_range(30, 9);
        else
            len = $urandom_range(45, 33);
        sel = $urandom_range(99);
        mode = (sel < 10) ? 0 : (sel < 15) ? 1 : 2;
        split_last = (len == 0) || ($urandom_range(99) < 10);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 8)
                send_item(DIGIT_W'($urandom), 1'b0, 1'b0);
            pick_digit(mode, d);
            send_item(d, 1'b1, !split_last && i == len - 1);
        end
        if (split_last)
            send_item(DIGIT_W'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int strings;
        sb = new();
        sent = 0;
        stall_cycles = 0;
        strings = 0;
        rst_n = 1'b0;
        digit_ch.valid = 1'b0;
        digit_ch.digit = '0;
        digit_ch.has_digit = 1'b0;
        digit_ch.last = 1'b0;
        frac_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(4'd0, 1'b0, 1'b1);
        send_item(4'd0, 1'b1, 1'b1);
        send_item(4'd9, 1'b1, 1'b1);
        send_item(4'd15, 1'b1, 1'b1);
        send_item(4'd5, 1'b1, 1'b1);
        send_item(4'd1, 1'b1, 1'b0);
        send_item(4'd7, 1'b0, 1'b0);
        send_item(4'd2, 1'b1, 1'b0);
        send_item(4'd12, 1'b0, 1'b1);
        send_item(4'd8, 1'b1, 1'b0);
        send_item(4'd6, 1'b1, 1'b1);
        send_item(4'd10, 1'b1, 1'b0);
        send_item(4'd11, 1'b1, 1'b0);
        send_item(4'd13, 1'b1, 1'b0);
        send_item(4'd14, 1'b1, 1'b1);

        while (sent < ITEM_TARGET)
        begin
            send_random_string();
            strings++;
            if (strings == 60)
            begin
                // hold the sender until every fraction has drained
                digit_ch.valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
        end
        digit_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
